// File: hw/rtl/vlm_pkg.sv
`default_nettype none

package vlm_pkg;

  // datapath widths of the shared divider
  localparam int NUM_W = 38;
  localparam int DEN_W = 21;
  localparam int QUO_W = 21;
  localparam int QN_W  = 16;
  localparam int CNT_W = $clog2(QUO_W + 1);

  // signed accumulator for the frame-to-render numerator
  localparam int ACC_W = 40;

  // item commands
  localparam logic [1:0] CMD_RECOMPUTE = 2'd0;
  localparam logic [1:0] CMD_TO_FRAME  = 2'd1;
  localparam logic [1:0] CMD_TO_RENDER = 2'd2;

  // scaling modes
  localparam logic [1:0] MODE_ASPECT  = 2'd0;
  localparam logic [1:0] MODE_FILL    = 2'd1;
  localparam logic [1:0] MODE_INTEGER = 2'd2;
  localparam logic [1:0] MODE_DYNAMIC = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_WIN_W = 2'd1;
  localparam logic [1:0] REG_WIN_H = 2'd2;

  // divider request from the sequencer
  typedef struct packed {
    logic start;
    logic wide;
  } div_ctl_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic done;
    logic ovf;
  } div_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/vlm_div.sv
`default_nettype none

// radix-2 restoring divider, one quotient bit per cycle
// narrow requests take 16 quotient bits, wide ones 21
// ovf flags a quotient that does not fit the requested bit count
module vlm_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire vlm_pkg::div_ctl_t              ctl,
  input  wire logic [vlm_pkg::NUM_W-1:0]      num,
  input  wire logic [vlm_pkg::DEN_W-1:0]      den,
  output vlm_pkg::div_sts_t                   sts,
  output logic      [vlm_pkg::QUO_W-1:0]      quot
);

  localparam int SH_W = vlm_pkg::DEN_W + vlm_pkg::QUO_W;

  logic [vlm_pkg::NUM_W-1:0] rem_r;
  logic [SH_W-1:0]           dsh_r;
  logic [vlm_pkg::QUO_W-1:0] quot_r;
  logic [vlm_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic                      ovf_r;

  logic [SH_W-1:0] den_ext;
  logic [SH_W-1:0] lim;
  logic [SH_W-1:0] dsh_init;
  logic            fits;

  // limit and first trial divisor for the requested quotient size
  assign den_ext  = SH_W'(den);
  assign lim      = ctl.wide ? (den_ext << vlm_pkg::QUO_W) : (den_ext << vlm_pkg::QN_W);
  assign dsh_init = ctl.wide ? (den_ext << (vlm_pkg::QUO_W - 1))
                             : (den_ext << (vlm_pkg::QN_W - 1));

  // trial subtract of the shifted divisor
  assign fits = SH_W'(rem_r) >= dsh_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.wide ? vlm_pkg::CNT_W'(vlm_pkg::QUO_W) : vlm_pkg::CNT_W'(vlm_pkg::QN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == vlm_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder, divisor and quotient shift registers
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r  <= num;
      dsh_r  <= dsh_init;
      quot_r <= '0;
      ovf_r  <= SH_W'(num) >= lim;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r[vlm_pkg::NUM_W-1:0];
      end
      dsh_r  <= dsh_r >> 1;
      quot_r <= {quot_r[vlm_pkg::QUO_W-2:0], fits};
    end
  end

  assign sts.done = done_r;
  assign sts.ovf  = ovf_r;
  assign quot     = quot_r;

endmodule

`default_nettype wire

// File: hw/rtl/viewport_letterbox_mapper_core.sv
`default_nettype none

// Fits a FRAME_WIDTH x FRAME_HEIGHT logical frame into a configured window.
// Configuration: cfg_valid/cfg_ready write port, cfg_index selects the scaling
// mode (0), window width (1) or window height (2); cfg_ready is always high.
// Input items (in_valid/in_stall) carry a command and an x/y coordinate:
// recompute the viewport, map window pixels to frame coordinates, or map
// frame coordinates (4 fraction bits) to render pixels. Each item gives one
// result item (out_valid/out_stall) with the mapped pair and the current
// render size and centering offset in 8-bit fixed point.
// One item is worked at a time; the work is a sequencer around a shared
// radix-2 divider that yields one quotient bit per cycle. Fill and dynamic
// recompute and command three use no division; in window to frame mapping a
// zero render size or a point at or before the image start skips the divider
// on that axis. The result is registered as the block goes back to idle, in
// the cycle before it can take its next item. A stalled result holds in the
// output register while the next item is already being worked; the block then
// waits with its finished result until the output register frees.
// Synchronous reset restores the default window, mode and full-frame view.
module viewport_letterbox_mapper_core #(
  parameter int FRAME_WIDTH  = 1280,
  parameter int FRAME_HEIGHT = 720
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [12:0]        cfg_data,
  // input items
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [16:0]        in_coord_x,
  input  wire logic [16:0]        in_coord_y,
  // result items
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [14:0]      out_mapped_x,
  output logic signed [14:0]      out_mapped_y,
  output logic signed [21:0]      out_view_offset_x,
  output logic signed [21:0]      out_view_offset_y,
  output logic        [20:0]      out_view_width,
  output logic        [20:0]      out_view_height
);

  localparam int NUM_W = vlm_pkg::NUM_W;
  localparam int DEN_W = vlm_pkg::DEN_W;
  localparam int QUO_W = vlm_pkg::QUO_W;
  localparam int QN_W  = vlm_pkg::QN_W;
  localparam int ACC_W = vlm_pkg::ACC_W;

  localparam logic [12:0]        FW_C   = 13'(FRAME_WIDTH);
  localparam logic [12:0]        FH_C   = 13'(FRAME_HEIGHT);
  localparam logic signed [17:0] FWK_C  = 18'(16 * FRAME_WIDTH);
  localparam logic signed [17:0] FHK_C  = 18'(16 * FRAME_HEIGHT);
  localparam logic [20:0]        RW_RST = 21'(FRAME_WIDTH * 256);
  localparam logic [20:0]        RH_RST = 21'(FRAME_HEIGHT * 256);
  localparam logic [12:0]        WW_RST = 13'd1280;
  localparam logic [12:0]        WH_RST = 13'd720;
  localparam logic [14:0]        S15_MAX = 15'h3FFF;
  localparam logic [14:0]        S15_MIN = 15'h4000;
  localparam logic [15:0]        MAG_MAX = 16'd16383;
  localparam logic [15:0]        MAG_MIN = 16'd16384;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LOAD  = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_ABS   = 8'b0000_1000,
    ST_START = 8'b0001_0000,
    ST_WAIT  = 8'b0010_0000,
    ST_POST  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration and viewport state
  logic [1:0]         mode_r;
  logic [12:0]        win_w_r;
  logic [12:0]        win_h_r;
  logic signed [21:0] off_x_r;
  logic signed [21:0] off_y_r;
  logic [20:0]        rend_w_r;
  logic [20:0]        rend_h_r;

  // item and working registers
  logic [1:0]              cmd_r;
  logic [16:0]             cx_r;
  logic [16:0]             cy_r;
  logic                    axis_r;
  logic                    wider_r;
  logic                    neg_r;
  logic                    wide_r;
  logic [QN_W-1:0]         sx_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [NUM_W-1:0]        num_r;
  logic [DEN_W-1:0]        den_r;
  logic signed [14:0]      mx_r;
  logic signed [14:0]      my_r;

  // output register
  logic               out_valid_r;
  logic signed [14:0] o_mx_r;
  logic signed [14:0] o_my_r;
  logic signed [21:0] o_ox_r;
  logic signed [21:0] o_oy_r;
  logic [20:0]        o_rw_r;
  logic [20:0]        o_rh_r;

  vlm_pkg::div_ctl_t  div_ctl;
  vlm_pkg::div_sts_t  div_sts;
  logic [QUO_W-1:0]   quot;

  logic in_accept;
  logic out_load;
  logic last_axis;

  // per-axis operand selection
  logic [16:0]        c_sel;
  logic signed [21:0] off_sel;
  logic [20:0]        size_sel;
  logic [12:0]        frm_sel;
  logic signed [17:0] frmk_sel;

  // load-step arithmetic
  logic [25:0]             wfh;
  logic [25:0]             hfw;
  logic                    wider;
  logic signed [26:0]      diff;
  logic                    skip_w2f;
  logic signed [ACC_W-1:0] offk;

  // multiply-step arithmetic
  logic [38:0]             prod_w2f;
  logic [37:0]             prod_f2r;
  logic signed [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0]        mag;

  // post-step arithmetic
  logic [QN_W-1:0]    q16;
  logic [12:0]        w2f_res;
  logic [14:0]        f2r_res;
  logic [14:0]        map_res;
  logic [20:0]        span;
  logic [QN_W-1:0]    sxc;
  logic [QN_W-1:0]    syc;
  logic [QN_W-1:0]    s_min;
  logic [28:0]        fs_w;
  logic [28:0]        fs_h;
  logic [20:0]        rw_int;
  logic [20:0]        rh_int;
  logic signed [22:0] ox_full;
  logic signed [22:0] oy_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // aspect recompute uses one division; integer recompute and mappings run both axes
  assign last_axis = axis_r ||
                     ((cmd_r == vlm_pkg::CMD_RECOMPUTE) && (mode_r != vlm_pkg::MODE_INTEGER));

  assign c_sel    = axis_r ? cy_r     : cx_r;
  assign off_sel  = axis_r ? off_y_r  : off_x_r;
  assign size_sel = axis_r ? rend_h_r : rend_w_r;
  assign frm_sel  = axis_r ? FH_C     : FW_C;
  assign frmk_sel = axis_r ? FHK_C    : FWK_C;

  // aspect compare by cross multiplication
  assign wfh   = win_w_r * FH_C;
  assign hfw   = win_h_r * FW_C;
  assign wider = wfh > hfw;

  // window to frame: shift the pixel into 8-bit fixed point, remove offset
  assign diff     = $signed({2'b00, c_sel, 8'h00}) - off_sel;
  assign skip_w2f = (size_sel == '0) || diff[26] || (diff == '0);

  // frame to render: offset term, then add the scaled coordinate
  assign offk     = off_sel * frmk_sel;
  assign prod_w2f = acc_r[25:0] * frm_sel;
  assign prod_f2r = c_sel * size_sel;
  assign acc_sum  = acc_r + $signed({2'b00, prod_f2r});
  assign mag      = acc_r[ACC_W-1] ? -acc_r : acc_r;

  // window to frame result, clamped to the frame
  assign q16     = quot[QN_W-1:0];
  assign w2f_res = (div_sts.ovf || (q16 > {3'b000, frm_sel})) ? frm_sel : q16[12:0];

  // frame to render result, saturated to the mapped range
  always_comb begin
    if (neg_r) begin
      if (div_sts.ovf || (q16 > MAG_MIN)) begin
        f2r_res = S15_MIN;
      end else begin
        f2r_res = 15'(17'd0 - {1'b0, q16});
      end
    end else begin
      if (div_sts.ovf || (q16 > MAG_MAX)) begin
        f2r_res = S15_MAX;
      end else begin
        f2r_res = q16[14:0];
      end
    end
  end

  assign map_res = (cmd_r == vlm_pkg::CMD_TO_FRAME) ? {2'b00, w2f_res} : f2r_res;

  // aspect mode: the slack on the long axis halves into the offset
  assign span = (wider_r ? {win_w_r, 8'h00} : {win_h_r, 8'h00}) - quot;

  // integer mode: smallest whole scale of at least one
  assign sxc    = (sx_r == '0) ? QN_W'(1) : sx_r;
  assign syc    = (q16 == '0) ? QN_W'(1) : q16;
  assign s_min  = (sxc < syc) ? sxc : syc;
  assign fs_w   = FW_C * s_min;
  assign fs_h   = FH_C * s_min;
  assign rw_int = {fs_w[12:0], 8'h00};
  assign rh_int = {fs_h[12:0], 8'h00};
  assign ox_full = $signed({2'b00, win_w_r, 8'h00}) - $signed({2'b00, rw_int});
  assign oy_full = $signed({2'b00, win_h_r, 8'h00}) - $signed({2'b00, rh_int});

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        case (cmd_r)
          vlm_pkg::CMD_RECOMPUTE: begin
            unique case (mode_r) inside
              vlm_pkg::MODE_ASPECT, vlm_pkg::MODE_INTEGER: state_nxt = ST_START;
              default:                                     state_nxt = ST_DONE;
            endcase
          end
          vlm_pkg::CMD_TO_FRAME: begin
            if (!skip_w2f) begin
              state_nxt = ST_MUL;
            end else if (last_axis) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_LOAD;
            end
          end
          vlm_pkg::CMD_TO_RENDER: state_nxt = ST_MUL;
          default:                state_nxt = ST_DONE;
        endcase
      end
      ST_MUL: begin
        state_nxt = (cmd_r == vlm_pkg::CMD_TO_FRAME) ? ST_START : ST_ABS;
      end
      ST_ABS:   state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_sts.done) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        state_nxt = last_axis ? ST_DONE : ST_LOAD;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control, configuration and viewport state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= vlm_pkg::MODE_ASPECT;
      win_w_r     <= WW_RST;
      win_h_r     <= WH_RST;
      off_x_r     <= '0;
      off_y_r     <= '0;
      rend_w_r    <= RW_RST;
      rend_h_r    <= RH_RST;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          vlm_pkg::REG_MODE:  mode_r  <= cfg_data[1:0];
          vlm_pkg::REG_WIN_W: win_w_r <= cfg_data;
          vlm_pkg::REG_WIN_H: win_h_r <= cfg_data;
          default: ;
        endcase
      end

      // axis walk
      if (in_accept) begin
        axis_r <= 1'b0;
      end else if (((state_r == ST_POST) || ((state_r == ST_LOAD) && skip_w2f &&
                   (cmd_r == vlm_pkg::CMD_TO_FRAME))) && !last_axis) begin
        axis_r <= 1'b1;
      end

      // fill and dynamic modes take the window as is
      if ((state_r == ST_LOAD) && (cmd_r == vlm_pkg::CMD_RECOMPUTE) &&
          ((mode_r == vlm_pkg::MODE_FILL) || (mode_r == vlm_pkg::MODE_DYNAMIC))) begin
        rend_w_r <= {win_w_r, 8'h00};
        rend_h_r <= {win_h_r, 8'h00};
        off_x_r  <= '0;
        off_y_r  <= '0;
      end

      // divided recompute results
      if ((state_r == ST_POST) && (cmd_r == vlm_pkg::CMD_RECOMPUTE)) begin
        if (mode_r == vlm_pkg::MODE_ASPECT) begin
          if (wider_r) begin
            rend_w_r <= quot;
            rend_h_r <= {win_h_r, 8'h00};
            off_x_r  <= {2'b00, span[20:1]};
            off_y_r  <= '0;
          end else begin
            rend_w_r <= {win_w_r, 8'h00};
            rend_h_r <= quot;
            off_x_r  <= '0;
            off_y_r  <= {2'b00, span[20:1]};
          end
        end else if (axis_r) begin
          rend_w_r <= rw_int;
          rend_h_r <= rh_int;
          off_x_r  <= ox_full[22:1];
          off_y_r  <= oy_full[22:1];
        end
      end

      // output handshake
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and working datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= in_cmd;
      cx_r  <= in_coord_x;
      cy_r  <= in_coord_y;
      mx_r  <= '0;
      my_r  <= '0;
    end

    // operand setup
    if (state_r == ST_LOAD) begin
      case (cmd_r)
        vlm_pkg::CMD_RECOMPUTE: begin
          if (mode_r == vlm_pkg::MODE_ASPECT) begin
            wider_r <= wider;
            num_r   <= wider ? NUM_W'({hfw, 8'h00}) : NUM_W'({wfh, 8'h00});
            den_r   <= wider ? DEN_W'(FH_C) : DEN_W'(FW_C);
            wide_r  <= 1'b1;
          end else begin
            num_r  <= axis_r ? NUM_W'(win_h_r) : NUM_W'(win_w_r);
            den_r  <= DEN_W'(frm_sel);
            wide_r <= 1'b0;
          end
        end
        vlm_pkg::CMD_TO_FRAME: begin
          acc_r  <= ACC_W'(diff);
          den_r  <= size_sel;
          wide_r <= 1'b0;
        end
        vlm_pkg::CMD_TO_RENDER: begin
          acc_r  <= offk;
          den_r  <= DEN_W'(frm_sel);
          wide_r <= 1'b0;
        end
        default: ;
      endcase
    end

    // numerator products
    if (state_r == ST_MUL) begin
      if (cmd_r == vlm_pkg::CMD_TO_FRAME) begin
        num_r <= prod_w2f[NUM_W-1:0];
      end else begin
        acc_r <= acc_sum;
      end
    end

    // magnitude, with the fixed-point and fraction scaling dropped
    if (state_r == ST_ABS) begin
      num_r <= NUM_W'(mag[ACC_W-1:12]);
      neg_r <= acc_r[ACC_W-1];
    end

    // quotient consumers
    if (state_r == ST_POST) begin
      if (cmd_r == vlm_pkg::CMD_RECOMPUTE) begin
        if (!axis_r) begin
          sx_r <= q16;
        end
      end else if (axis_r) begin
        my_r <= map_res;
      end else begin
        mx_r <= map_res;
      end
    end

    // output register
    if (out_load) begin
      o_mx_r <= mx_r;
      o_my_r <= my_r;
      o_ox_r <= off_x_r;
      o_oy_r <= off_y_r;
      o_rw_r <= rend_w_r;
      o_rh_r <= rend_h_r;
    end
  end

  assign div_ctl.start = (state_r == ST_START);
  assign div_ctl.wide  = wide_r;

  vlm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (num_r),
    .den   (den_r),
    .sts   (div_sts),
    .quot  (quot)
  );

  assign out_valid         = out_valid_r;
  assign out_mapped_x      = o_mx_r;
  assign out_mapped_y      = o_my_r;
  assign out_view_offset_x = o_ox_r;
  assign out_view_offset_y = o_oy_r;
  assign out_view_width    = o_rw_r;
  assign out_view_height   = o_rh_r;

endmodule

`default_nettype wire

// File: hw/rtl/vlm_checker.sv
`default_nettype none

module vlm_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [14:0] out_mapped_x,
  input wire logic signed [14:0] out_mapped_y,
  input wire logic signed [21:0] out_view_offset_x,
  input wire logic signed [21:0] out_view_offset_y,
  input wire logic        [20:0] out_view_width,
  input wire logic        [20:0] out_view_height
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mapped_x) &&
      $stable(out_mapped_y) && $stable(out_view_offset_x) && $stable(out_view_offset_y) &&
      $stable(out_view_width) && $stable(out_view_height))
    else $error("result changed while stalled");

  // one item in flight: an accepted item closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an accept");

  // a new result only follows a busy interval
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind viewport_letterbox_mapper_core vlm_checker u_vlm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_mapped_x      (out_mapped_x),
  .out_mapped_y      (out_mapped_y),
  .out_view_offset_x (out_view_offset_x),
  .out_view_offset_y (out_view_offset_y),
  .out_view_width    (out_view_width),
  .out_view_height   (out_view_height)
);

`default_nettype wire
